// File: src/pulse_position_speed_counter_top_assert.svh
// Assertion macros for the pulse position and speed counter checker.
// No dependencies; expects clk and arst_n in the scope of use.
`ifndef PULSE_POSITION_SPEED_COUNTER_TOP_ASSERT_SVH
`define PULSE_POSITION_SPEED_COUNTER_TOP_ASSERT_SVH

// checked only out of reset
`define PPSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PPSC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ppsc_pkg.sv
// Shared widths, constants and types of the pulse position and speed counter.
// No dependencies.
package ppsc_pkg;

	localparam int DATA_W           = 32;
	localparam int POS_W            = 31;
	localparam int DIV_STEPS        = DATA_W;
	localparam int CNT_W            = $clog2(DIV_STEPS);

	localparam logic [POS_W-1:0]  POS_MAX          = {POS_W{1'b1}};
	localparam logic [DATA_W-1:0] TIMER_RATE_RESET = DATA_W'(1000000);
	localparam logic [CNT_W-1:0]  CNT_LAST         = CNT_W'(DIV_STEPS - 1);

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: src/ppsc_if.sv
// Valid/ready channel interfaces for pulse beats and result beats.
// Depends on ppsc_pkg.
interface ppsc_in_if;
	logic                        valid;
	logic                        ready;
	logic                        direction;
	logic [ppsc_pkg::DATA_W-1:0] timestamp;

	modport source (output valid, output direction, output timestamp, input ready);
	modport sink   (input valid, input direction, input timestamp, output ready);
endinterface

interface ppsc_out_if;
	logic                        valid;
	logic                        ready;
	logic [ppsc_pkg::POS_W-1:0]  position;
	logic [ppsc_pkg::DATA_W-1:0] pulse_total;
	logic [ppsc_pkg::DATA_W-1:0] speed;

	modport source (output valid, output position, output pulse_total, output speed,
		input ready);
	modport sink   (input valid, input position, input pulse_total, input speed,
		output ready);
endinterface

// File: src/pulse_position_speed_counter_top.sv
// Pulse position and speed counter, top level with sequencer and counters.
// Depends on ppsc_pkg, ppsc_if and ppsc_div.
//
// Each input beat is one sensor pulse. Position moves down on direction 1 and up
// otherwise, held at zero and at its 31-bit maximum; pulse_total wraps. Speed is
// timer_rate divided by the wrapping timestamp gap to the previous pulse and is held
// when the gap is zero. The quotient comes from a bit-serial divider, one bit per
// cycle. After a pulse is accepted the input stays not ready while the sequencer
// is in ST_DIV (nonzero gap only) and ST_FIN; a stalled result beat adds its wait.
// timer_rate is written through cfg_wr_en/cfg_wr_data and resets to 1000000.
module pulse_position_speed_counter_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [ppsc_pkg::DATA_W-1:0] cfg_wr_data,
	ppsc_in_if.sink                     in_ch,
	ppsc_out_if.source                  out_ch
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                      state_q;
	logic [ppsc_pkg::DATA_W-1:0] timer_rate_q;
	logic [ppsc_pkg::POS_W-1:0]  pos_q;
	logic [ppsc_pkg::DATA_W-1:0] total_q;
	logic [ppsc_pkg::DATA_W-1:0] speed_q;
	logic [ppsc_pkg::DATA_W-1:0] last_q;
	logic                        out_valid_q;
	logic [ppsc_pkg::POS_W-1:0]  out_pos_q;
	logic [ppsc_pkg::DATA_W-1:0] out_total_q;
	logic [ppsc_pkg::DATA_W-1:0] out_speed_q;

	logic                        in_acc;
	logic                        out_load;
	logic [ppsc_pkg::DATA_W-1:0] gap;
	logic                        div_start;
	logic [ppsc_pkg::DATA_W-1:0] quotient;
	ppsc_pkg::div_stat_t         div_stat;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_load    = (state_q == ST_FIN) && (!out_valid_q || out_ch.ready);
	assign gap         = in_ch.timestamp - last_q;
	assign div_start   = in_acc && (gap != '0);

	ppsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (timer_rate_q),
		.divisor  (gap),
		.quotient (quotient),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			timer_rate_q <= ppsc_pkg::TIMER_RATE_RESET;
			pos_q        <= '0;
			total_q      <= '0;
			speed_q      <= '0;
			last_q       <= '0;
			out_valid_q  <= 1'b0;
			out_pos_q    <= '0;
			out_total_q  <= '0;
			out_speed_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				timer_rate_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_ch.direction) begin
							if (pos_q != '0) begin
								pos_q <= pos_q - 1'b1;
							end
						end else if (pos_q != ppsc_pkg::POS_MAX) begin
							pos_q <= pos_q + 1'b1;
						end
						total_q <= total_q + 1'b1;
						last_q  <= in_ch.timestamp;
						state_q <= div_start ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						speed_q <= quotient;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						out_pos_q   <= pos_q;
						out_total_q <= total_q;
						out_speed_q <= speed_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.position    = out_pos_q;
	assign out_ch.pulse_total = out_total_q;
	assign out_ch.speed       = out_speed_q;

endmodule

// File: src/ppsc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ppsc_pkg.
module ppsc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ppsc_pkg::DATA_W-1:0] dividend,
	input  logic [ppsc_pkg::DATA_W-1:0] divisor,
	output logic [ppsc_pkg::DATA_W-1:0] quotient,
	output ppsc_pkg::div_stat_t         stat
);

	logic [ppsc_pkg::DATA_W-1:0] rem_q;
	logic [ppsc_pkg::DATA_W-1:0] quo_q;
	logic [ppsc_pkg::DATA_W-1:0] dvs_q;
	logic [ppsc_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [ppsc_pkg::DATA_W:0]   trial;
	logic [ppsc_pkg::DATA_W:0]   shifted;

	assign shifted = {rem_q, quo_q[ppsc_pkg::DATA_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ppsc_pkg::CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[ppsc_pkg::DATA_W]) begin
				rem_q <= trial[ppsc_pkg::DATA_W-1:0];
				quo_q <= {quo_q[ppsc_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[ppsc_pkg::DATA_W-1:0];
				quo_q <= {quo_q[ppsc_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: src/ppsc_checker.sv
// Port-level checker for the pulse position and speed counter, bound to the top.
// Depends on ppsc_pkg and pulse_position_speed_counter_top_assert.svh.
`include "pulse_position_speed_counter_top_assert.svh"

module ppsc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ppsc_pkg::POS_W-1:0]  position,
	input logic [ppsc_pkg::DATA_W-1:0] pulse_total,
	input logic [ppsc_pkg::DATA_W-1:0] speed
);

	`PPSC_ASSERT(a_busy_after_beat, in_valid && in_ready |=> !in_ready, "ready after input beat")
	`PPSC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(position) && $stable(pulse_total) && $stable(speed), "result beat dropped")
	`PPSC_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(!in_ready), "result without work")
	`PPSC_ASSERT_ALWAYS(a_reset_state, !arst_n |-> !out_valid && in_ready, "reset state wrong")

endmodule

bind pulse_position_speed_counter_top ppsc_checker u_ppsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.position    (out_ch.position),
	.pulse_total (out_ch.pulse_total),
	.speed       (out_ch.speed)
);

// File: sim/pulse_position_speed_counter_top_tb.sv
// Testbench for pulse_position_speed_counter_top: random and directed sensor pulses,
// per-beat prediction of position, pulse total and speed, across several timer rates.
// Depends on ppsc_pkg, ppsc_if and the top level RTL.
module pulse_position_speed_counter_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT   = 36;
	localparam int SETTLE     = 40;
	localparam int STALL_AT   = 400;
	localparam int STALL_LEN  = 600;
	localparam int WATCHDOG   = 5000;

	typedef struct packed {
		logic                        direction;
		logic [ppsc_pkg::DATA_W-1:0] timestamp;
	} pulse_t;

	typedef struct packed {
		logic [ppsc_pkg::POS_W-1:0]  position;
		logic [ppsc_pkg::DATA_W-1:0] pulse_total;
		logic [ppsc_pkg::DATA_W-1:0] speed;
	} report_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_wr_en;
	logic [ppsc_pkg::DATA_W-1:0] cfg_wr_data;

	ppsc_in_if  pulse_ch ();
	ppsc_out_if report_ch ();

	pulse_position_speed_counter_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (pulse_ch),
		.out_ch      (report_ch)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// predictor state
	logic [ppsc_pkg::POS_W-1:0]  pos_now;
	logic [ppsc_pkg::DATA_W-1:0] total_now;
	logic [ppsc_pkg::DATA_W-1:0] speed_now;
	logic [ppsc_pkg::DATA_W-1:0] last_ts;
	logic [ppsc_pkg::DATA_W-1:0] rate_now;

	pulse_t  pending_pulses[$];
	report_t report_q[$];
	pulse_t  next_pulse;
	report_t got;
	report_t want;

	// stimulus generator state
	logic [ppsc_pkg::DATA_W-1:0] gen_ts;
	logic                        run_dir;
	int                          run_left;

	int  pushed_total;
	int  results_seen;
	int  errors;
	int  stall_left;
	bit  stall_done;
	bit  steady;
	int  quiet_cycles;

	function automatic void track_pulse(input logic dir,
			input logic [ppsc_pkg::DATA_W-1:0] ts);
		logic [ppsc_pkg::DATA_W-1:0] gap;
		report_t r;
		if (dir) begin
			if (pos_now != '0)
				pos_now = pos_now - 1'b1;
		end else if (pos_now != ppsc_pkg::POS_MAX) begin
			pos_now = pos_now + 1'b1;
		end
		total_now = total_now + 1'b1;
		gap = ts - last_ts;
		if (gap != '0)
			speed_now = rate_now / gap;
		last_ts = ts;
		r.position    = pos_now;
		r.pulse_total = total_now;
		r.speed       = speed_now;
		report_q.push_back(r);
	endfunction

	task automatic queue_at(input logic dir, input logic [ppsc_pkg::DATA_W-1:0] ts);
		pulse_t p;
		p.direction = dir;
		p.timestamp = ts;
		gen_ts = ts;
		pending_pulses.push_back(p);
		pushed_total++;
	endtask

	task automatic queue_gap(input logic dir, input logic [ppsc_pkg::DATA_W-1:0] gap);
		queue_at(dir, gen_ts + gap);
	endtask

	task automatic queue_random(input int count);
		int pick;
		logic dir;
		logic [ppsc_pkg::DATA_W-1:0] gap;
		for (int i = 0; i < count; i++) begin
			if (run_left == 0) begin
				run_dir  = 1'($urandom_range(1));
				run_left = $urandom_range(60, 1);
			end
			run_left--;
			dir  = ($urandom_range(99) < 10) ? 1'($urandom_range(1)) : run_dir;
			pick = $urandom_range(99);
			if (pick < 10)
				gap = '0;
			else if (pick < 55)
				gap = $urandom_range(1000, 1);
			else if (pick < 80)
				gap = $urandom_range(32'h000F_FFFF, 1);
			else
				gap = $urandom;
			if (pick >= 95)
				queue_at(dir, $urandom);
			else
				queue_gap(dir, gap);
		end
	endtask

	task automatic queue_edges();
		queue_gap(1'b0, 32'd1);
		queue_gap(1'b0, 32'd0);
		queue_gap(1'b1, 32'hFFFF_FFFF);
		queue_gap(1'b1, 32'd2);
	endtask

	task automatic drain();
		@(negedge clk);
		while (results_seen != pushed_total)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_rate(input logic [ppsc_pkg::DATA_W-1:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		rate_now = value;
		@(negedge clk);
	endtask

	// pulse driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_ch.valid     <= 1'b0;
			pulse_ch.direction <= 1'b0;
			pulse_ch.timestamp <= '0;
		end else begin
			if (pulse_ch.valid && pulse_ch.ready)
				track_pulse(pulse_ch.direction, pulse_ch.timestamp);
			if (!pulse_ch.valid || pulse_ch.ready) begin
				if (pending_pulses.size() != 0 &&
						(steady || $urandom_range(99) >= IDLE_PCT)) begin
					next_pulse = pending_pulses.pop_front();
					pulse_ch.valid     <= 1'b1;
					pulse_ch.direction <= next_pulse.direction;
					pulse_ch.timestamp <= next_pulse.timestamp;
				end else begin
					pulse_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (report_ch.valid && report_ch.ready) begin
				results_seen++;
				got.position    = report_ch.position;
				got.pulse_total = report_ch.pulse_total;
				got.speed       = report_ch.speed;
				if (report_q.size() == 0) begin
					$error("result beat with no pulse pending");
					errors++;
				end else begin
					want = report_q.pop_front();
					if (got.position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position, got.position);
						errors++;
					end
					if (got.pulse_total !== want.pulse_total) begin
						$error("pulse_total: expected %0d, got %0d",
							want.pulse_total, got.pulse_total);
						errors++;
					end
					if (got.speed !== want.speed) begin
						$error("speed: expected %0d, got %0d", want.speed, got.speed);
						errors++;
					end
				end
			end
			if (!stall_done && results_seen == STALL_AT) begin
				stall_left = STALL_LEN;
				stall_done = 1'b1;
			end
			if (stall_left > 0) begin
				stall_left--;
				report_ch.ready <= 1'b0;
			end else begin
				report_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if ((pulse_ch.valid && pulse_ch.ready) || (report_ch.valid && report_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("pulse_position_speed_counter_top_tb failed");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_wr_data  <= ppsc_pkg::TIMER_RATE_RESET;
		pos_now      = '0;
		total_now    = '0;
		speed_now    = '0;
		last_ts      = '0;
		rate_now     = ppsc_pkg::TIMER_RATE_RESET;
		gen_ts       = '0;
		run_dir      = 1'b0;
		run_left     = 0;
		pushed_total = 0;
		results_seen = 0;
		errors       = 0;
		stall_done   = 1'b0;
		steady       = 1'b0;
		quiet_cycles = 0;

		// first pulse measured from zero, down at zero, zero gap, wrap, full-scale gap
		queue_at(1'b1, 32'd5);
		queue_at(1'b1, 32'd5);
		queue_at(1'b0, 32'd6);
		queue_at(1'b0, 32'd1000006);
		queue_at(1'b0, 32'd2000008);
		queue_at(1'b0, 32'h7FFF_FFFF);
		queue_at(1'b0, 32'hFFFF_FFFF);
		queue_at(1'b0, 32'h0000_0000);
		queue_at(1'b1, 32'h0000_0000);
		queue_at(1'b0, 32'h8000_0000);
		queue_at(1'b1, 32'h7FFF_FFFF);
		repeat (6) queue_gap(1'b1, 32'd3);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		queue_random(200);
		drain();

		write_rate(32'd1);
		queue_edges();
		queue_random(210);
		drain();

		write_rate(32'hFFFF_FFFF);
		queue_edges();
		queue_random(100);
		drain();
		queue_random(110);
		drain();

		write_rate(32'd0);
		queue_edges();
		steady = 1'b1;
		queue_random(210);
		drain();
		steady = 1'b0;

		write_rate($urandom);
		queue_edges();
		queue_random(210);
		drain();

		write_rate($urandom_range(1000, 1));
		queue_edges();
		queue_random(210);
		drain();

		write_rate(ppsc_pkg::TIMER_RATE_RESET);
		queue_edges();
		queue_random(200);
		drain();

		if (report_q.size() != 0) begin
			$error("%0d expected results never arrived", report_q.size());
			errors++;
		end
		if (errors == 0)
			$display("pulse_position_speed_counter_top_tb passed");
		else
			$display("pulse_position_speed_counter_top_tb failed");
		$finish;
	end

endmodule
